FILE: sv/fse_pkg.sv
// Shared types, widths and codes of the frame stack engine.
package fse_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 11;
  localparam int OFFSET_W = 11;
  localparam int READ_W   = 32;
  localparam int INDEX_W  = 10;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH       = 3'd0,
    FN_POP        = 3'd1,
    FN_PUSH_FRAME = 3'd2,
    FN_POP_FRAME  = 3'd3,
    FN_PUSH_ZEROS = 3'd4,
    FN_POP_COUNT  = 3'd5,
    FN_TOP        = 3'd6,
    FN_READ_OFF   = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BOUNDS    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ZERO
  } state_t;

  typedef struct packed {
    logic [READ_W-1:0]  read_word;
    status_t            status;
    logic               is_empty;
    logic [INDEX_W-1:0] top_index;
    logic [INDEX_W-1:0] base_index;
  } res_t;

endpackage

FILE: sv/fse_in_if.sv
// Request channel into the frame stack engine.
interface fse_in_if;
  logic                                valid;
  logic                                ready;
  logic [fse_pkg::FUNC_W-1:0]          func;
  logic [fse_pkg::VALUE_W-1:0]         value;
  logic [fse_pkg::COUNT_W-1:0]         count;
  logic signed [fse_pkg::OFFSET_W-1:0] offset;

  modport source (output valid, func, value, count, offset, input ready);
  modport sink   (input valid, func, value, count, offset, output ready);
endinterface

FILE: sv/fse_out_if.sv
// Result channel out of the frame stack engine.
interface fse_out_if;
  logic                         valid;
  logic                         ready;
  logic [fse_pkg::READ_W-1:0]   read_word;
  logic [1:0]                   status;
  logic                         is_empty;
  logic [fse_pkg::INDEX_W-1:0]  top_index;
  logic [fse_pkg::INDEX_W-1:0]  base_index;

  modport source (output valid, read_word, status, is_empty, top_index, base_index,
                  input ready);
  modport sink   (input valid, read_word, status, is_empty, top_index, base_index,
                  output ready);
endinterface

FILE: sv/fse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/frame_stack_engine.sv
// Frame stack engine top level: word stack with frame base pointer in one RAM.
//
// Channel   Direction  Carries
// in_req    sink       func, value, count, offset
// out_req   source     read_word, status, is_empty, top_index, base_index
//
// Push, pop, push frame, pop count and any flagged request complete in S_IDLE.
// Read top, read at offset and pop frame pass through S_READ for the registered RAM read.
// Push zeros with a nonzero count passes through S_ZERO, one slot written per cycle on the RAM write port.
// Reset clears the state, the pointers and the result valid flags only; slot 0 is never written and reads as zero.
// A two-entry result buffer lets a new request in while a result waits.
module frame_stack_engine #(
  parameter int DEPTH     = fse_pkg::DEPTH_DEF,
  parameter int WORD_BITS = fse_pkg::WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  fse_in_if.sink           in_req,
  fse_out_if.source        out_req
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = ((PW > fse_pkg::COUNT_W) ? PW : fse_pkg::COUNT_W) + 1;
  localparam int XW = ((PW > fse_pkg::OFFSET_W) ? PW : fse_pkg::OFFSET_W) + 2;

  fse_pkg::state_t state_r, state_nxt;
  fse_pkg::func_t  op_r, op_nxt;
  logic [PW-1:0]   top_r, top_nxt;
  logic [PW-1:0]   base_r, base_nxt;
  logic [fse_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic            zero_rd_r, zero_rd_nxt;

  logic            out_valid_r, out_valid_nxt;
  fse_pkg::res_t   out_r, out_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  fse_pkg::res_t   skid_r, skid_nxt;

  logic                 we;
  logic [PW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [PW-1:0]        raddr;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] word;

  logic                 accept;
  logic                 done;
  fse_pkg::res_t        res;
  fse_pkg::status_t     status;
  logic [fse_pkg::READ_W-1:0] rd_word;
  fse_pkg::func_t       func;

  logic [PW-1:0]   top_inc;
  logic [PW-1:0]   base_dec;
  logic            top_ovf;
  logic            zeros_ovf;
  logic            count_big;
  logic signed [XW-1:0] idx;
  logic            idx_oob;

  fse_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign func      = fse_pkg::func_t'(in_req.func);
  assign in_req.ready = (state_r == fse_pkg::S_IDLE) && !skid_valid_r;
  assign accept    = in_req.valid && in_req.ready;

  assign top_inc   = top_r + PW'(1);
  assign base_dec  = base_r - PW'(1);
  assign top_ovf   = ({1'b0, top_r} + (PW+1)'(1)) >= (PW+1)'(DEPTH);
  assign zeros_ovf = (CW'(top_r) + CW'(in_req.count)) >= CW'(DEPTH);
  assign count_big = CW'(in_req.count) > CW'(top_r - base_r);
  assign idx       = signed'(XW'(base_r)) + XW'(in_req.offset);
  assign idx_oob   = (idx < 0) || (idx > signed'(XW'(top_r)));
  assign word      = zero_rd_r ? '0 : rdata;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    top_nxt     = top_r;
    base_nxt    = base_r;
    cnt_nxt     = cnt_r;
    zero_rd_nxt = zero_rd_r;
    we          = 1'b0;
    waddr       = top_inc;
    wdata       = '0;
    raddr       = top_r;
    done        = 1'b0;
    status      = fse_pkg::ST_OK;
    rd_word     = '0;

    unique case (state_r)
      fse_pkg::S_IDLE: begin
        if (accept) begin
          unique case (func)
            fse_pkg::FN_PUSH: begin
              done = 1'b1;
              if (top_ovf) begin
                status = fse_pkg::ST_OVERFLOW;
              end else begin
                top_nxt = top_inc;
                we      = 1'b1;
                wdata   = WORD_BITS'(in_req.value);
              end
            end
            fse_pkg::FN_POP: begin
              done = 1'b1;
              if (top_r > base_r) begin
                top_nxt = top_r - PW'(1);
              end else begin
                status = fse_pkg::ST_UNDERFLOW;
              end
            end
            fse_pkg::FN_PUSH_FRAME: begin
              done = 1'b1;
              if (top_ovf) begin
                status = fse_pkg::ST_OVERFLOW;
              end else begin
                top_nxt  = top_inc;
                base_nxt = top_inc;
                we       = 1'b1;
                wdata    = WORD_BITS'(base_r);
              end
            end
            fse_pkg::FN_POP_FRAME: begin
              if (base_r == '0) begin
                done   = 1'b1;
                status = fse_pkg::ST_UNDERFLOW;
              end else begin
                raddr       = base_r;
                zero_rd_nxt = 1'b0;
                op_nxt      = fse_pkg::FN_POP_FRAME;
                state_nxt   = fse_pkg::S_READ;
              end
            end
            fse_pkg::FN_PUSH_ZEROS: begin
              if (zeros_ovf) begin
                done   = 1'b1;
                status = fse_pkg::ST_OVERFLOW;
              end else if (in_req.count == '0) begin
                done = 1'b1;
              end else begin
                cnt_nxt   = in_req.count;
                state_nxt = fse_pkg::S_ZERO;
              end
            end
            fse_pkg::FN_POP_COUNT: begin
              done = 1'b1;
              if (count_big) begin
                status = fse_pkg::ST_UNDERFLOW;
              end else begin
                top_nxt = top_r - PW'(in_req.count);
              end
            end
            fse_pkg::FN_TOP: begin
              raddr       = top_r;
              zero_rd_nxt = (top_r == '0);
              op_nxt      = fse_pkg::FN_TOP;
              state_nxt   = fse_pkg::S_READ;
            end
            fse_pkg::FN_READ_OFF: begin
              if (idx_oob) begin
                done   = 1'b1;
                status = fse_pkg::ST_BOUNDS;
              end else begin
                raddr       = idx[PW-1:0];
                zero_rd_nxt = (idx == '0);
                op_nxt      = fse_pkg::FN_READ_OFF;
                state_nxt   = fse_pkg::S_READ;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      fse_pkg::S_READ: begin
        done      = 1'b1;
        state_nxt = fse_pkg::S_IDLE;
        if (op_r == fse_pkg::FN_POP_FRAME) begin
          top_nxt  = base_dec;
          base_nxt = (word > WORD_BITS'(base_dec)) ? base_dec : word[PW-1:0];
        end else begin
          rd_word = fse_pkg::READ_W'(word);
        end
      end
      fse_pkg::S_ZERO: begin
        we      = 1'b1;
        wdata   = '0;
        top_nxt = top_inc;
        cnt_nxt = cnt_r - fse_pkg::COUNT_W'(1);
        if (cnt_r == fse_pkg::COUNT_W'(1)) begin
          done      = 1'b1;
          state_nxt = fse_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fse_pkg::S_IDLE;
      end
    endcase

    res.read_word  = rd_word;
    res.status     = status;
    res.is_empty   = (top_nxt <= base_nxt);
    res.top_index  = fse_pkg::INDEX_W'(top_nxt);
    res.base_index = fse_pkg::INDEX_W'(base_nxt);
  end

  // result buffer: head register plus one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    priority if (done) begin
      if (out_valid_r && !out_req.ready) begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res;
      end else begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end
    end else if (out_valid_r && out_req.ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fse_pkg::S_IDLE;
      top_r        <= '0;
      base_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      top_r        <= top_nxt;
      base_r       <= base_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    cnt_r     <= cnt_nxt;
    zero_rd_r <= zero_rd_nxt;
    out_r     <= out_nxt;
    skid_r    <= skid_nxt;
  end

  assign out_req.valid      = out_valid_r;
  assign out_req.read_word  = out_r.read_word;
  assign out_req.status     = out_r.status;
  assign out_req.is_empty   = out_r.is_empty;
  assign out_req.top_index  = out_r.top_index;
  assign out_req.base_index = out_r.base_index;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the frame stack engine: directed corner cases, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fse_pkg::*;

  localparam int LONG_HOLD  = 300;
  localparam int NUM_RANDOM = 1650;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  class stack_scoreboard;
    bit [VALUE_W-1:0] slot_mem [DEPTH_DEF];
    int top_idx;
    int base_idx;
    res_t replies_due[$];
    int mismatches;

    function new();
      foreach (slot_mem[i]) slot_mem[i] = '0;
      top_idx = 0;
      base_idx = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction

    function res_t exec_stack_op(func_t fn, bit [VALUE_W-1:0] value, int cnt, int offs);
      res_t r;
      int idx;
      bit [VALUE_W-1:0] saved;
      r = '0;
      r.status = ST_OK;
      case (fn)
        FN_PUSH: begin
          if (top_idx + 1 >= DEPTH_DEF) begin
            r.status = ST_OVERFLOW;
          end else begin
            top_idx++;
            slot_mem[top_idx] = value;
          end
        end
        FN_POP: begin
          if (top_idx > base_idx) top_idx--;
          else r.status = ST_UNDERFLOW;
        end
        FN_PUSH_FRAME: begin
          if (top_idx + 1 >= DEPTH_DEF) begin
            r.status = ST_OVERFLOW;
          end else begin
            top_idx++;
            slot_mem[top_idx] = VALUE_W'(base_idx);
            base_idx = top_idx;
          end
        end
        FN_POP_FRAME: begin
          if (base_idx == 0) begin
            r.status = ST_UNDERFLOW;
          end else begin
            saved = slot_mem[base_idx];
            top_idx = base_idx - 1;
            base_idx = (saved > VALUE_W'(top_idx)) ? top_idx : int'(saved);
          end
        end
        FN_PUSH_ZEROS: begin
          if (top_idx + cnt >= DEPTH_DEF) begin
            r.status = ST_OVERFLOW;
          end else begin
            for (int i = 0; i < cnt; i++) begin
              top_idx++;
              slot_mem[top_idx] = '0;
            end
          end
        end
        FN_POP_COUNT: begin
          if (cnt > top_idx - base_idx) r.status = ST_UNDERFLOW;
          else top_idx -= cnt;
        end
        FN_TOP: begin
          r.read_word = slot_mem[top_idx];
        end
        default: begin
          idx = base_idx + offs;
          if (idx < 0 || idx > top_idx) r.status = ST_BOUNDS;
          else r.read_word = slot_mem[idx];
        end
      endcase
      r.is_empty   = (top_idx <= base_idx);
      r.top_index  = INDEX_W'(top_idx);
      r.base_index = INDEX_W'(base_idx);
      return r;
    endfunction

    function void note_request(func_t fn, logic [VALUE_W-1:0] value,
                               logic [COUNT_W-1:0] cnt, logic signed [OFFSET_W-1:0] offs);
      replies_due.push_back(exec_stack_op(fn, value, int'(cnt), int'(offs)));
    endfunction

    function void check_result(logic [READ_W-1:0] rd, logic [1:0] st, logic emp,
                               logic [INDEX_W-1:0] top, logic [INDEX_W-1:0] base);
      res_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result rd=%h st=%0d empty=%0b top=%0d base=%0d",
                   $realtime, rd, st, emp, top, base);
        return;
      end
      want = replies_due.pop_front();
      if (rd !== want.read_word || st !== want.status || emp !== want.is_empty ||
          top !== want.top_index || base !== want.base_index) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: mismatch exp rd=%h st=%0d empty=%0b top=%0d base=%0d",
                 $realtime, want.read_word, want.status, want.is_empty, want.top_index,
                 want.base_index);
          $display(" / act rd=%h st=%0d empty=%0b top=%0d base=%0d",
                   rd, st, emp, top, base);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fse_in_if  in_req ();
  fse_out_if out_req ();

  frame_stack_engine dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_req (out_req)
  );

  stack_scoreboard sb;
  int holds_asked = 0;
  int holds_served = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  task automatic send_request(func_t fn, logic [VALUE_W-1:0] value,
                              logic [COUNT_W-1:0] cnt, logic signed [OFFSET_W-1:0] offs);
    in_req.valid  <= 1'b1;
    in_req.func   <= fn;
    in_req.value  <= value;
    in_req.count  <= cnt;
    in_req.offset <= offs;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(fn, value, cnt, offs);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end
  endtask

  task automatic drain_results();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic run_corner_cases();
    send_request(FN_TOP, '0, '0, '0);
    send_request(FN_POP, '0, '0, '0);
    send_request(FN_POP_FRAME, '0, '0, '0);
    send_request(FN_POP_COUNT, '0, 11'd0, '0);
    send_request(FN_POP_COUNT, '0, 11'h7FF, '0);
    send_request(FN_PUSH, 32'hFFFF_FFFF, '0, '0);
    send_request(FN_PUSH, 32'h0000_0000, 11'h7FF, 11'h7FF);
    send_request(FN_READ_OFF, '0, '0, -11'sd1);
    send_request(FN_READ_OFF, '0, '0, 11'sd1);
    send_request(FN_READ_OFF, '0, '0, 11'sd3);
    send_request(FN_READ_OFF, '0, '0, 11'sd1023);
    send_request(FN_READ_OFF, '0, '0, 11'h400);
    send_request(FN_PUSH_FRAME, '0, '0, '0);
    send_request(FN_PUSH, 32'hA5A5_5A5A, '0, '0);
    send_request(FN_READ_OFF, '0, '0, -11'sd2);
    send_request(FN_READ_OFF, '0, '0, 11'sd0);
    send_request(FN_PUSH_ZEROS, '0, 11'd0, '0);
    send_request(FN_PUSH_ZEROS, '0, 11'd3, '0);
    send_request(FN_POP_COUNT, '0, 11'd2, '0);
    send_request(FN_POP_FRAME, '0, '0, '0);
    send_request(FN_PUSH_ZEROS, '0, 11'h7FF, '0);
    send_request(FN_PUSH_ZEROS, '0, COUNT_W'(DEPTH_DEF - 2 - sb.top_idx), '0);
    send_request(FN_PUSH, 32'h1234_5678, '0, '0);
    send_request(FN_PUSH_FRAME, '0, '0, '0);
    send_request(FN_PUSH_ZEROS, '0, 11'd1, '0);
    send_request(FN_TOP, '0, '0, '0);
    send_request(FN_POP_COUNT, '0, COUNT_W'(sb.top_idx - sb.base_idx), '0);
  endtask

  task automatic random_request();
    int r, span, pick;
    func_t fn;
    logic [VALUE_W-1:0] v;
    logic [COUNT_W-1:0] c;
    logic signed [OFFSET_W-1:0] o;
    v = $urandom;
    c = COUNT_W'($urandom_range(0, 6));
    o = '0;
    span = sb.top_idx - sb.base_idx;
    r = $urandom_range(0, 99);
    if (sb.top_idx > 900 && $urandom_range(0, 3) == 0) r = 60;
    if (r < 24) begin
      fn = FN_PUSH;
    end else if (r < 35) begin
      fn = FN_POP;
    end else if (r < 43) begin
      fn = FN_PUSH_FRAME;
    end else if (r < 50) begin
      fn = FN_POP_FRAME;
    end else if (r < 58) begin
      fn = FN_PUSH_ZEROS;
      if ($urandom_range(0, 9) == 0) c = COUNT_W'($urandom_range(0, 2047));
    end else if (r < 66) begin
      fn = FN_POP_COUNT;
      c = COUNT_W'($urandom_range(0, span + 1));
      if ($urandom_range(0, 7) == 0) c = COUNT_W'($urandom_range(0, 2047));
    end else if (r < 73) begin
      fn = FN_TOP;
    end else if (r < 92) begin
      fn = FN_READ_OFF;
      pick = int'($urandom_range(0, span + 1 + sb.base_idx)) - sb.base_idx;
      o = OFFSET_W'(pick);
    end else begin
      // noise: any operation, any field contents
      fn = func_t'($urandom_range(0, 7));
      c = COUNT_W'($urandom_range(0, 2047));
      o = OFFSET_W'($urandom);
    end
    send_request(fn, v, c, o);
  endtask

  // result side: random stall modes plus requested long hold-offs
  initial begin
    int hold_left, mode_left, phase;
    rx_mode_t mode;
    out_req.ready = 1'b0;
    hold_left = 0;
    mode_left = 0;
    phase = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_req.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        out_req.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   out_req.ready <= 1'b1;
          RX_RANDOM: out_req.ready <= 1'($urandom_range(0, 1));
          default:   out_req.ready <= ((phase % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_req.valid && out_req.ready)
      sb.check_result(out_req.read_word, out_req.status, out_req.is_empty,
                      out_req.top_index, out_req.base_index);
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_req.valid  = 1'b0;
    in_req.func   = FN_PUSH;
    in_req.value  = '0;
    in_req.count  = '0;
    in_req.offset = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_corner_cases();
    drain_results();
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 400 || n == 1200) begin
        holds_asked++;
        burst_left = 400;
      end
      if (n == 900) drain_results();
      random_request();
      pace_sender();
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
sv/fse_pkg.sv
sv/fse_in_if.sv
sv/fse_out_if.sv
sv/fse_ram.sv
sv/frame_stack_engine.sv
verif/testbench.sv
